[hw/rtl/tmcw_pkg.sv]
// Shared constants, operation codes and memory request types of the text-mode
// console writer. No dependencies.
`default_nettype none

package tmcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Cell store address and sweep source widths (source may run one screen past the end)
  localparam int AW = $clog2(CELLS);
  localparam int SW = $clog2(2 * CELLS + 1);

  localparam int CELL_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADR_W  = 11;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0700;
  localparam logic [CELL_W-1:0] NEWLINE_CELL = 16'h0020;
  localparam logic [7:0]        NEWLINE_CODE = 8'd10;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_SETPOS = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [AW-1:0]     addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

[hw/rtl/tmcw_screen_ram.sv]
// Screen cell store: one write port, one read port, registered read data.
// Depends on tmcw_pkg.
`default_nettype none

module tmcw_screen_ram (
  input  wire logic                       clk,
  input  wire tmcw_pkg::mem_wr_t          wr,
  input  wire tmcw_pkg::mem_rd_t          rd,
  output logic [tmcw_pkg::CELL_W-1:0]     rdata
);

  logic [tmcw_pkg::CELL_W-1:0] cells [tmcw_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cells[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= cells[rd.addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tmcw_sweep.sv]
// Scroll and clear engine: walks every cell, copying from a fixed offset ahead
// or filling blank where the source lies past the screen. Depends on tmcw_pkg.
`default_nettype none

module tmcw_sweep (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [tmcw_pkg::SW-1:0]    offset,
  input  wire logic [tmcw_pkg::CELL_W-1:0] rdata,
  output tmcw_pkg::mem_rd_t               rd,
  output tmcw_pkg::mem_wr_t               wr,
  output logic                            busy
);

  logic                     active;
  logic [tmcw_pkg::AW-1:0]  dst;
  logic [tmcw_pkg::SW-1:0]  off;
  logic                     pend;
  logic [tmcw_pkg::AW-1:0]  pend_dst;
  logic                     pend_mem;
  logic [tmcw_pkg::SW-1:0]  src;
  logic                     src_in;

  assign src    = tmcw_pkg::SW'(dst) + off;
  assign src_in = (src < tmcw_pkg::SW'(tmcw_pkg::CELLS));

  assign rd.en   = active && src_in;
  assign rd.addr = src[tmcw_pkg::AW-1:0];

  assign wr.en   = pend;
  assign wr.addr = pend_dst;
  assign wr.data = pend_mem ? rdata : tmcw_pkg::BLANK_CELL;

  assign busy = active || pend;

  // Reset starts a full blank pass
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      dst    <= '0;
      off    <= tmcw_pkg::SW'(tmcw_pkg::CELLS);
      pend   <= 1'b0;
    end else begin
      pend <= active;
      if (start) begin
        active <= 1'b1;
        dst    <= '0;
        off    <= offset;
      end else if (active) begin
        if (dst == tmcw_pkg::AW'(tmcw_pkg::CELLS - 1)) begin
          active <= 1'b0;
        end else begin
          dst <= dst + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_dst <= dst;
    pend_mem <= src_in;
  end

endmodule

`default_nettype wire

[hw/rtl/text_mode_console_writer.sv]
// Text-mode console writer top level: command decode, cursor, result register.
// Depends on tmcw_pkg, tmcw_screen_ram and tmcw_sweep.
// A command word is accepted in the idle state and its result is registered out of
// the finish state; a scroll or clear first runs a sweep over every cell. A new word
// is taken only once the last result has been loaded, and none while a sweep runs. Reset:
// synchronous, blank pass over every cell with in_ready low; cursor 0,0, shown.
`default_nettype none

module text_mode_console_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: cursor enable
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  // Command words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  char_code,
  input  wire logic [3:0]  fg_color,
  input  wire logic [3:0]  bg_color,
  input  wire logic [7:0]  column,
  input  wire logic [7:0]  row,
  // Result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      cell_value,
  output logic [6:0]       cursor_column,
  output logic [4:0]       cursor_row,
  output logic [10:0]      cursor_address,
  output logic             cursor_visible
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_INIT  = 2'd3;

  logic [1:0]                   state;
  logic [tmcw_pkg::COL_W-1:0]   cur_col;
  logic [tmcw_pkg::ROW_W-1:0]   cur_row;
  logic                         cursor_enabled;
  logic                         op_read;

  logic [tmcw_pkg::COL_W-1:0]   cur_col_next;
  logic [tmcw_pkg::ROW_W-1:0]   cur_row_next;
  logic                         sw_start;
  logic [tmcw_pkg::SW-1:0]      sw_off;
  logic                         accept;
  logic                         load_out;

  // Put char decode
  logic                         is_nl;
  logic [tmcw_pkg::COL_W:0]     col_p1;
  logic                         row_inc;
  logic [tmcw_pkg::ROW_W:0]     row_p;
  // Set position / read cell decode
  logic [7:0]                   col_clamp;
  logic [7:0]                   row_clamp;
  logic [7:0]                   scroll_rows;

  tmcw_pkg::mem_rd_t            cmd_rd, sw_rd, mem_rd;
  tmcw_pkg::mem_wr_t            cmd_wr, sw_wr, mem_wr;
  logic [tmcw_pkg::CELL_W-1:0]  rdata;
  logic                         sw_busy;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    is_nl   = (char_code == tmcw_pkg::NEWLINE_CODE);
    col_p1  = {1'b0, cur_col} + 1'b1;
    row_inc = is_nl || (col_p1 >= (tmcw_pkg::COL_W+1)'(tmcw_pkg::COLUMNS));
    row_p   = {1'b0, cur_row} + (tmcw_pkg::ROW_W+1)'(row_inc);

    col_clamp = (column >= 8'(tmcw_pkg::COLUMNS)) ? 8'(tmcw_pkg::COLUMNS - 1) : column;
    row_clamp = (row >= 8'(tmcw_pkg::ROWS)) ? 8'(tmcw_pkg::ROWS - 1) : row;
    // Scrolling a full screen or more leaves only blanks
    scroll_rows = row - 8'(tmcw_pkg::ROWS - 1);
    if (scroll_rows > 8'(tmcw_pkg::ROWS)) begin
      scroll_rows = 8'(tmcw_pkg::ROWS);
    end

    // Write the character at the cursor
    cmd_wr.en   = accept && (operation == tmcw_pkg::OP_PUT);
    cmd_wr.addr = tmcw_pkg::AW'(cur_row * tmcw_pkg::COLUMNS + cur_col);
    cmd_wr.data = is_nl ? tmcw_pkg::NEWLINE_CELL : {bg_color, fg_color, char_code};

    cmd_rd.en   = accept && (operation == tmcw_pkg::OP_READ);
    cmd_rd.addr = tmcw_pkg::AW'(row_clamp[tmcw_pkg::ROW_W-1:0] * tmcw_pkg::COLUMNS
                                + col_clamp);

    cur_col_next = cur_col;
    cur_row_next = cur_row;
    sw_start     = 1'b0;
    sw_off       = tmcw_pkg::SW'(tmcw_pkg::CELLS);
    unique case (operation)
      tmcw_pkg::OP_PUT: begin
        cur_col_next = row_inc ? '0 : col_p1[tmcw_pkg::COL_W-1:0];
        if (row_p >= (tmcw_pkg::ROW_W+1)'(tmcw_pkg::ROWS)) begin
          // Past the bottom: scroll one row and park on the last row
          cur_row_next = tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1);
          sw_start     = accept;
          sw_off       = tmcw_pkg::SW'(tmcw_pkg::COLUMNS);
        end else begin
          cur_row_next = row_p[tmcw_pkg::ROW_W-1:0];
        end
      end
      tmcw_pkg::OP_SETPOS: begin
        cur_col_next = col_clamp[tmcw_pkg::COL_W-1:0];
        cur_row_next = row_clamp[tmcw_pkg::ROW_W-1:0];
        if (row >= 8'(tmcw_pkg::ROWS)) begin
          sw_start = accept;
          sw_off   = tmcw_pkg::SW'(scroll_rows * tmcw_pkg::COLUMNS);
        end
      end
      tmcw_pkg::OP_CLEAR: begin
        cur_col_next = '0;
        cur_row_next = '0;
        sw_start     = accept;
      end
      tmcw_pkg::OP_READ: begin
      end
      default: begin
      end
    endcase

    // Sweep and command never use the store in the same cycle
    mem_wr = cmd_wr.en ? cmd_wr : sw_wr;
    mem_rd = cmd_rd.en ? cmd_rd : sw_rd;
  end

  tmcw_screen_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (rdata)
  );

  tmcw_sweep u_sweep (
    .clk    (clk),
    .rst    (rst),
    .start  (sw_start),
    .offset (sw_off),
    .rdata  (rdata),
    .rd     (sw_rd),
    .wr     (sw_wr),
    .busy   (sw_busy)
  );

  // Control: sequencer, cursor, configuration and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      cur_col        <= '0;
      cur_row        <= '0;
      cursor_enabled <= 1'b1;
      op_read        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cursor_enabled <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_col <= cur_col_next;
            cur_row <= cur_row_next;
            op_read <= (operation == tmcw_pkg::OP_READ);
            state   <= sw_start ? ST_SWEEP : ST_FIN;
          end
        end
        ST_SWEEP: begin
          // Hold until the last copy or blank has been written back
          if (!sw_busy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        ST_INIT: begin
          // Hold input off until the reset blank pass is done; no word to report
          if (!sw_busy) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      cell_value     <= op_read ? rdata : '0;
      cursor_column  <= cur_col;
      cursor_row     <= cur_row;
      cursor_address <= tmcw_pkg::ADR_W'(cur_row * tmcw_pkg::COLUMNS + cur_col);
      cursor_visible <= cursor_enabled;
    end
  end

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the text-mode console writer: a table of opening
// commands, then random text, cursor moves, clears and reads against a
// predictor of the screen. Depends on tmcw_pkg and text_mode_console_writer.

module tb;
  import tmcw_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

  typedef struct packed {
    logic [15:0] value;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] addr;
    logic        shown;
  } status_t;

  // One opening command; where typed is set the status is written out by hand
  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    status_t want;
  } opening_step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_READ;
  logic [7:0]  char_code = '0;
  logic [3:0]  fg_color = '0;
  logic [3:0]  bg_color = '0;
  logic [7:0]  column = '0;
  logic [7:0]  row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] cell_value;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_address;
  logic        cursor_visible;

  // Predicted console: the cell store, the cursor and the enable bit
  logic [15:0] screen_mem [CELLS];
  int          cur_col;
  int          cur_row;
  logic        cursor_on;

  status_t     status_due [$];
  int          mismatches = 0;
  int          words_seen = 0;
  int          op_count [4] = '{0, 0, 0, 0};
  int          scroll_count = 0;
  int          enable_writes = 0;
  int          text_left = 0;
  bit          sender_calm = 1'b0;
  bit          sink_calm = 1'b0;

  opening_step_t opening_steps [25] = '{
    // read home and the clamped far corner straight after reset
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd0, 8'd0}, 1'b1,
      '{BLANK_CELL, 7'd0, 5'd0, 11'd0, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd255, 8'd255}, 1'b1,
      '{BLANK_CELL, 7'd0, 5'd0, 11'd0, 1'b1}},
    // colour and character extremes
    '{'{OP_PUT, 8'h41, 4'hf, 4'hf, 8'd0, 8'd0}, 1'b1,
      '{16'h0000, 7'd1, 5'd0, 11'd1, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd0, 8'd0}, 1'b1,
      '{16'hff41, 7'd1, 5'd0, 11'd1, 1'b1}},
    '{'{OP_PUT, 8'h00, 4'h0, 4'h0, 8'd0, 8'd0}, 1'b1,
      '{16'h0000, 7'd2, 5'd0, 11'd2, 1'b1}},
    '{'{OP_PUT, 8'hff, 4'h5, 4'ha, 8'd0, 8'd0}, 1'b1,
      '{16'h0000, 7'd3, 5'd0, 11'd3, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd2, 8'd0}, 1'b1,
      '{16'ha5ff, 7'd3, 5'd0, 11'd3, 1'b1}},
    // newline leaves a bare space and drops to the next row
    '{'{OP_PUT, NEWLINE_CODE, 4'h3, 4'h4, 8'd0, 8'd0}, 1'b1,
      '{16'h0000, 7'd0, 5'd1, 11'd80, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd3, 8'd0}, 1'b1,
      '{NEWLINE_CELL, 7'd0, 5'd1, 11'd80, 1'b1}},
    // column clamp, then wrap off the last column
    '{'{OP_SETPOS, 8'h00, 4'h0, 4'h0, 8'd255, 8'd0}, 1'b1,
      '{16'h0000, 7'd79, 5'd0, 11'd79, 1'b1}},
    '{'{OP_PUT, 8'h5a, 4'h1, 4'h2, 8'd0, 8'd0}, 1'b1,
      '{16'h0000, 7'd0, 5'd1, 11'd80, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd79, 8'd0}, 1'b1,
      '{16'h215a, 7'd0, 5'd1, 11'd80, 1'b1}},
    // fill the bottom-right corner and scroll off it
    '{'{OP_SETPOS, 8'h00, 4'h0, 4'h0, 8'd78, 8'd24}, 1'b1,
      '{16'h0000, 7'd78, 5'd24, 11'd1998, 1'b1}},
    '{'{OP_PUT, 8'h78, 4'h7, 4'h0, 8'd0, 8'd0}, 1'b1,
      '{16'h0000, 7'd79, 5'd24, 11'd1999, 1'b1}},
    '{'{OP_PUT, 8'h79, 4'h7, 4'h0, 8'd0, 8'd0}, 1'b1,
      '{16'h0000, 7'd0, 5'd24, 11'd1920, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd79, 8'd23}, 1'b0, '0},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd0, 8'd24}, 1'b1,
      '{BLANK_CELL, 7'd0, 5'd24, 11'd1920, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd79, 8'd0}, 1'b0, '0},
    // newline on the bottom row scrolls too
    '{'{OP_PUT, NEWLINE_CODE, 4'hf, 4'hf, 8'd0, 8'd0}, 1'b0, '0},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd0, 8'd23}, 1'b0, '0},
    // moves below the bottom: two scrolls, then the deepest row there is
    '{'{OP_SETPOS, 8'h00, 4'h0, 4'h0, 8'd0, 8'd26}, 1'b1,
      '{16'h0000, 7'd0, 5'd24, 11'd1920, 1'b1}},
    '{'{OP_SETPOS, 8'h00, 4'h0, 4'h0, 8'd5, 8'd255}, 1'b1,
      '{16'h0000, 7'd5, 5'd24, 11'd1925, 1'b1}},
    '{'{OP_PUT, 8'h80, 4'h0, 4'hf, 8'd0, 8'd0}, 1'b0, '0},
    // clear ignores every other field
    '{'{OP_CLEAR, 8'hff, 4'hf, 4'hf, 8'd255, 8'd255}, 1'b1,
      '{16'h0000, 7'd0, 5'd0, 11'd0, 1'b1}},
    '{'{OP_READ, 8'h00, 4'h0, 4'h0, 8'd5, 8'd24}, 1'b1,
      '{BLANK_CELL, 7'd0, 5'd0, 11'd0, 1'b1}}
  };

  text_mode_console_writer i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .char_code      (char_code),
    .fg_color       (fg_color),
    .bg_color       (bg_color),
    .column         (column),
    .row            (row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cell_value     (cell_value),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .cursor_address (cursor_address),
    .cursor_visible (cursor_visible)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Shift every row up by one and blank the bottom row
  function automatic void scroll_screen();
    for (int i = 0; i + COLUMNS < CELLS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
    scroll_count++;
  endfunction

  // Apply one command word to the predicted console; return the status it reports
  function automatic status_t console_apply(input cmd_t c);
    status_t s;
    int      r;
    int      rd_col;
    int      rd_row;
    s = '0;
    case (c.op)
      OP_PUT: begin
        if (c.ch == NEWLINE_CODE) begin
          screen_mem[cur_row * COLUMNS + cur_col] = NEWLINE_CELL;
          cur_row++;
          cur_col = 0;
        end else begin
          screen_mem[cur_row * COLUMNS + cur_col] = {c.bg, c.fg, c.ch};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_row++;
          cur_col = 0;
        end
        if (cur_row >= ROWS) begin
          scroll_screen();
          cur_col = 0;
          cur_row = ROWS - 1;
        end
      end
      OP_SETPOS: begin
        cur_col = (c.col >= COLUMNS) ? COLUMNS - 1 : int'(c.col);
        r = int'(c.row);
        while (r >= ROWS) begin
          scroll_screen();
          r--;
        end
        cur_row = r;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        rd_col = (c.col >= COLUMNS) ? COLUMNS - 1 : int'(c.col);
        rd_row = (c.row >= ROWS) ? ROWS - 1 : int'(c.row);
        s.value = screen_mem[rd_row * COLUMNS + rd_col];
      end
    endcase
    s.col   = 7'(cur_col);
    s.row   = 5'(cur_row);
    s.addr  = 11'(cur_row * COLUMNS + cur_col);
    s.shown = cursor_on;
    return s;
  endfunction

  // Mostly runs of printable text with the odd newline; around them cursor
  // moves, reads anywhere (clamped or not) and a rare clear
  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    c.op  = OP_PUT;
    c.ch  = 8'($urandom);
    c.fg  = 4'($urandom);
    c.bg  = 4'($urandom);
    c.col = 8'($urandom);
    c.row = 8'($urandom);
    pick  = int'($urandom_range(0, 99));
    if (text_left > 0) begin
      text_left--;
      if (pick < 6) c.ch = NEWLINE_CODE;
      else if (pick < 92) c.ch = 8'($urandom_range(8'h20, 8'h7e));
      return c;
    end
    if (pick < 10) begin
      text_left = int'($urandom_range(4, 40));
    end else if (pick < 30) begin
      if ($urandom_range(0, 3) == 0) c.ch = NEWLINE_CODE;
    end else if (pick < 58) begin
      c.op = OP_SETPOS;
      // keep scrolls below the bottom rare: each one walks the whole store
      if ($urandom_range(0, 99) < 4) c.row = 8'($urandom_range(ROWS, ROWS + 3));
      else c.row = 8'($urandom_range(0, ROWS - 1));
    end else if (pick < 60) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_READ;
      if ($urandom_range(0, 1) == 0) begin
        c.col = 8'($urandom_range(0, COLUMNS - 1));
        c.row = 8'($urandom_range(0, ROWS - 1));
      end
    end
    return c;
  endfunction

  // Offer one command word after a random gap, hold it until taken, then predict
  task automatic issue(input cmd_t c, input logic typed, input status_t want);
    int      gap;
    status_t s;
    gap = sender_calm ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= c.op;
    char_code <= c.ch;
    fg_color  <= c.fg;
    bg_color  <= c.bg;
    column    <= c.col;
    row       <= c.row;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    s = console_apply(c);
    status_due.push_back(typed ? want : s);
    op_count[c.op]++;
    if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
  endtask

  // Drop valid and hold until every predicted status has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_cursor_enable(input logic v);
    wait_idle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    cursor_on = v;
    enable_writes++;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // now and then let the block drain completely before carrying on
      if (i % 150 == 149) wait_idle();
      issue(random_command(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int guard;
    for (int i = 0; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
    cur_col   = 0;
    cur_row   = 0;
    cursor_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Opening table, run with the cursor enable at its reset value
    foreach (opening_steps[i])
      issue(opening_steps[i].cmd, opening_steps[i].typed, opening_steps[i].want);

    // Random traffic with the cursor hidden, shown, then hidden again
    set_cursor_enable(1'b0);
    run_random(600);
    set_cursor_enable(1'b1);
    run_random(600);
    set_cursor_enable(1'b0);
    run_random(300);

    // Drain, then allow for a stray word well past the last expected one
    in_valid <= 1'b0;
    guard = 0;
    while (status_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * CELLS + 50) @(posedge clk);
    if (status_due.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", status_due.size()));

    $display("covered %0d put, %0d position, %0d clear and %0d read words, %0d scrolls",
             op_count[OP_PUT], op_count[OP_SETPOS], op_count[OP_CLEAR], op_count[OP_READ],
             scroll_count);
    $display("%0d result words checked, %0d cursor enable writes, %0d mismatches",
             words_seen, enable_writes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: stall at random, take each word and compare it with the oldest prediction
  initial begin : result_sink
    int      stall;
    status_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_calm ? 0 : int'($urandom_range(0, 10));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
      end else begin
        want = status_due.pop_front();
        if (cell_value !== want.value)
          report_mismatch($sformatf("word %0d cell_value %h, want %h",
                                    words_seen, cell_value, want.value));
        if (cursor_column !== want.col)
          report_mismatch($sformatf("word %0d cursor_column %0d, want %0d",
                                    words_seen, cursor_column, want.col));
        if (cursor_row !== want.row)
          report_mismatch($sformatf("word %0d cursor_row %0d, want %0d",
                                    words_seen, cursor_row, want.row));
        if (cursor_address !== want.addr)
          report_mismatch($sformatf("word %0d cursor_address %0d, want %0d",
                                    words_seen, cursor_address, want.addr));
        if (cursor_visible !== want.shown)
          report_mismatch($sformatf("word %0d cursor_visible %b, want %b",
                                    words_seen, cursor_visible, want.shown));
      end
      words_seen++;
      if ($urandom_range(0, 59) == 0) sink_calm = !sink_calm;
    end
  end

  // Hard stop: several times the slowest possible run, a full sweep on every word
  initial begin : watchdog
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_screen_ram.sv
hw/rtl/tmcw_sweep.sv
hw/rtl/text_mode_console_writer.sv
sim/tb.sv
